// ----- sv/voice_command_frame_parser_macros.svh -----
// assertion macros for the voice command frame parser
`ifndef VOICE_COMMAND_FRAME_PARSER_MACROS_SVH
`define VOICE_COMMAND_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define VCFP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define VCFP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define VCFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- sv/vcfp_pkg.sv -----
`default_nettype none
package vcfp_pkg;

  localparam logic [7:0] HDR1          = 8'hAA;
  localparam logic [7:0] HDR2          = 8'h55;
  localparam logic [7:0] FOOTER        = 8'hFB;
  localparam logic [7:0] CMD_FAN_FIRST = 8'h01;
  localparam logic [7:0] CMD_FAN_LAST  = 8'h05;
  localparam logic [7:0] CMD_LIGHT_OFF = 8'h0A;
  localparam logic [7:0] CMD_LIGHT_ON  = 8'h0B;

  // positions inside a frame and inside an acknowledgement
  localparam logic [2:0] POS_HDR1   = 3'd0;
  localparam logic [2:0] POS_HDR2   = 3'd1;
  localparam logic [2:0] POS_TYPE   = 3'd2;
  localparam logic [2:0] POS_CMD    = 3'd3;
  localparam logic [2:0] POS_FOOTER = 3'd4;

  // entries of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [2:0] fan_level;
    logic [6:0] fan_duty;
    logic       fan_manual;
    logic       lamp_on;
    logic       light_manual;
  } status_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] cmd;
    status_t    status;
  } ack_t;

  function automatic logic [6:0] duty_of(input logic [2:0] level);
    logic [6:0] duty;
    case (level)
      3'd0:    duty = 7'd0;
      3'd1:    duty = 7'd25;
      3'd2:    duty = 7'd50;
      3'd3:    duty = 7'd75;
      3'd4:    duty = 7'd100;
      default: duty = 7'd0;
    endcase
    return duty;
  endfunction

endpackage
`default_nettype wire

// ----- sv/vcfp_front.sv -----
`default_nettype none
module vcfp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    rx_byte,
  output vcfp_pkg::ack_t     ack,
  output logic               ack_push
);

  logic [2:0]       byte_position;
  logic [7:0]       frame_hdr2;
  logic [7:0]       frame_type;
  logic [7:0]       frame_cmd;
  vcfp_pkg::status_t status;
  vcfp_pkg::status_t status_next;
  logic             is_fan;
  logic             is_light;
  logic             framed;
  logic             complete;
  logic [2:0]       level;

  assign complete = accept && (byte_position == vcfp_pkg::POS_FOOTER);
  assign framed   = (frame_hdr2 == vcfp_pkg::HDR2) && (rx_byte == vcfp_pkg::FOOTER);
  assign is_fan   = (frame_cmd >= vcfp_pkg::CMD_FAN_FIRST) &&
                    (frame_cmd <= vcfp_pkg::CMD_FAN_LAST);
  assign is_light = (frame_cmd == vcfp_pkg::CMD_LIGHT_OFF) ||
                    (frame_cmd == vcfp_pkg::CMD_LIGHT_ON);
  assign level    = frame_cmd[2:0] - vcfp_pkg::CMD_FAN_FIRST[2:0];

  always_comb begin
    status_next = status;
    if (is_fan) begin
      status_next.fan_level  = level;
      status_next.fan_duty   = vcfp_pkg::duty_of(level);
      status_next.fan_manual = 1'b1;
    end else if (is_light) begin
      status_next.light_manual = 1'b1;
      status_next.lamp_on      = (frame_cmd == vcfp_pkg::CMD_LIGHT_ON);
    end
  end

  assign ack_push         = complete && framed && (is_fan || is_light);
  assign ack.frame_type   = frame_type;
  assign ack.cmd          = frame_cmd;
  assign ack.status       = status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= vcfp_pkg::POS_HDR1;
      status        <= '0;
    end else if (accept) begin
      case (byte_position)
        vcfp_pkg::POS_HDR1: begin
          // idle noise is dropped until a header byte shows up
          if (rx_byte == vcfp_pkg::HDR1) begin
            byte_position <= vcfp_pkg::POS_HDR2;
          end
        end
        vcfp_pkg::POS_HDR2: begin
          byte_position <= vcfp_pkg::POS_TYPE;
        end
        vcfp_pkg::POS_TYPE: begin
          byte_position <= vcfp_pkg::POS_CMD;
        end
        vcfp_pkg::POS_CMD: begin
          byte_position <= vcfp_pkg::POS_FOOTER;
        end
        default: begin
          byte_position <= vcfp_pkg::POS_HDR1;
          if (ack_push) begin
            status <= status_next;
          end
        end
      endcase
    end
  end

  // frame bytes, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      if (byte_position == vcfp_pkg::POS_HDR2) begin
        frame_hdr2 <= rx_byte;
      end
      if (byte_position == vcfp_pkg::POS_TYPE) begin
        frame_type <= rx_byte;
      end
      if (byte_position == vcfp_pkg::POS_CMD) begin
        frame_cmd <= rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/vcfp_queue.sv -----
`default_nettype none
module vcfp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire vcfp_pkg::ack_t wr_data,
  input  wire logic           rd_en,
  output vcfp_pkg::ack_t      rd_data,
  output logic                not_empty,
  output logic                is_full
);

  localparam int unsigned PW = $clog2(vcfp_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(vcfp_pkg::QDEPTH + 1);

  vcfp_pkg::ack_t entries [vcfp_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign not_empty = (count != '0);
  assign is_full   = (count == CW'(vcfp_pkg::QDEPTH));
  assign rd_data   = entries[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(vcfp_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/vcfp_back.sv -----
`default_nettype none
module vcfp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire vcfp_pkg::ack_t q_data,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire logic           pop,
  output logic                empty,
  output logic [7:0]          tx_byte,
  output logic                last_byte,
  output vcfp_pkg::status_t   status
);

  vcfp_pkg::ack_t cur;
  logic           busy;
  logic [2:0]     idx;
  logic           take;
  logic           done;

  assign empty     = !busy;
  assign take      = busy && pop;
  assign last_byte = (idx == vcfp_pkg::POS_FOOTER);
  assign done      = take && last_byte;
  // load the next ack when idle or as the last item of this one goes out
  assign q_pop     = q_valid && (!busy || done);
  assign status    = cur.status;

  always_comb begin
    case (idx)
      vcfp_pkg::POS_HDR1: tx_byte = vcfp_pkg::HDR1;
      vcfp_pkg::POS_HDR2: tx_byte = vcfp_pkg::HDR2;
      vcfp_pkg::POS_TYPE: tx_byte = cur.frame_type;
      vcfp_pkg::POS_CMD:  tx_byte = cur.cmd;
      default:            tx_byte = vcfp_pkg::FOOTER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= vcfp_pkg::POS_HDR1;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= vcfp_pkg::POS_HDR1;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= vcfp_pkg::POS_HDR1;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

endmodule
`default_nettype wire

// ----- sv/voice_command_frame_parser.sv -----
// Voice command frame parser. Takes one received byte per item through push/full and
// collects 5-byte frames AA 55 type cmd FB; bytes other than AA between frames are dropped.
// A well-framed frame with command 01..05 (fan level 0..4) or 0A/0B (light off/on)
// updates the fan or light status and queues an acknowledgement, which comes out as five
// result items AA 55 type cmd FB with last_byte on the fifth, each carrying the status
// after that command. One byte is accepted every cycle unless full is high; full rises only
// while the two-entry acknowledgement queue is full, since each acknowledgement needs five
// pops to drain, so the sustained rate is set by the result side at five pops per command.
`default_nettype none
`include "voice_command_frame_parser_macros.svh"
module voice_command_frame_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      tx_byte,
  output logic            last_byte,
  output logic [2:0]      fan_level,
  output logic [6:0]      fan_duty,
  output logic            fan_manual,
  output logic            lamp_on,
  output logic            light_manual
);

  vcfp_pkg::ack_t    front_ack;
  vcfp_pkg::ack_t    q_data;
  vcfp_pkg::status_t status;
  logic              accept;
  logic              ack_push;
  logic              q_valid;
  logic              q_pop;
  logic              q_full;

  assign full   = q_full;
  assign accept = push && !q_full;

  vcfp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .ack      (front_ack),
    .ack_push (ack_push)
  );

  vcfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (ack_push),
    .wr_data   (front_ack),
    .rd_en     (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .is_full   (q_full)
  );

  vcfp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .tx_byte   (tx_byte),
    .last_byte (last_byte),
    .status    (status)
  );

  assign fan_level    = status.fan_level;
  assign fan_duty     = status.fan_duty;
  assign fan_manual   = status.fan_manual;
  assign lamp_on      = status.lamp_on;
  assign light_manual = status.light_manual;

  `VCFP_ASSERT_NOW(a_last_is_footer, clk, rst, !empty && last_byte,
                   tx_byte == vcfp_pkg::FOOTER, "last item of an ack is not the footer")
  `VCFP_ASSERT_NEXT(a_ack_not_cut, clk, rst, !empty && !last_byte && pop,
                    !empty, "ack ended before its last item")
  `VCFP_ASSERT_NOW(a_no_push_when_full, clk, rst, ack_push,
                   !q_full, "ack pushed into a full queue")

endmodule
`default_nettype wire

// ----- dv/voice_command_frame_parser_tb.sv -----
`default_nettype none
module voice_command_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic [2:0] fan_level;
    logic [6:0] fan_duty;
    logic       fan_manual;
    logic       lamp_on;
    logic       light_manual;
  } ack_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       pop = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] tx_byte;
  logic       last_byte;
  logic [2:0] fan_level;
  logic [6:0] fan_duty;
  logic       fan_manual;
  logic       lamp_on;
  logic       light_manual;

  voice_command_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .rx_byte(rx_byte),
    .empty(empty),
    .pop(pop),
    .tx_byte(tx_byte),
    .last_byte(last_byte),
    .fan_level(fan_level),
    .fan_duty(fan_duty),
    .fan_manual(fan_manual),
    .lamp_on(lamp_on),
    .light_manual(light_manual)
  );

  always #1 clk = ~clk;

  // parser state as predicted from the accepted bytes
  int unsigned frame_pos = 0;
  logic [7:0]  frame_buf [5];
  logic [2:0]  fan_level_now = '0;
  logic [6:0]  fan_duty_now = '0;
  logic        fan_manual_now = 1'b0;
  logic        lamp_on_now = 1'b0;
  logic        light_manual_now = 1'b0;

  ack_beat_t ack_beats_due [$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned beats_checked = 0;
  int unsigned fan_acks = 0;
  int unsigned light_acks = 0;
  int unsigned frames_dropped = 0;
  int unsigned bytes_sent = 0;

  task automatic queue_ack(input logic [7:0] frame_type, input logic [7:0] cmd);
    logic [7:0] seq [5];
    ack_beat_t  beat;
    seq[0] = vcfp_pkg::HDR1;
    seq[1] = vcfp_pkg::HDR2;
    seq[2] = frame_type;
    seq[3] = cmd;
    seq[4] = vcfp_pkg::FOOTER;
    for (int k = 0; k < 5; k++) begin
      beat.tx_byte      = seq[k];
      beat.last_byte    = (k == 4);
      beat.fan_level    = fan_level_now;
      beat.fan_duty     = fan_duty_now;
      beat.fan_manual   = fan_manual_now;
      beat.lamp_on      = lamp_on_now;
      beat.light_manual = light_manual_now;
      ack_beats_due.push_back(beat);
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] cmd;
    logic [2:0] lvl;
    // stray bytes between frames are dropped
    if (frame_pos == 0 && b != vcfp_pkg::HDR1) return;
    frame_buf[frame_pos] = b;
    frame_pos++;
    if (frame_pos < 5) return;
    frame_pos = 0;
    cmd = frame_buf[3];
    if (frame_buf[1] != vcfp_pkg::HDR2 || frame_buf[4] != vcfp_pkg::FOOTER) begin
      frames_dropped++;
    end else if (cmd >= vcfp_pkg::CMD_FAN_FIRST && cmd <= vcfp_pkg::CMD_FAN_LAST) begin
      lvl = 3'(cmd - vcfp_pkg::CMD_FAN_FIRST);
      fan_level_now  = lvl;
      fan_duty_now   = 7'(lvl * 25);
      fan_manual_now = 1'b1;
      fan_acks++;
      queue_ack(frame_buf[2], cmd);
    end else if (cmd == vcfp_pkg::CMD_LIGHT_OFF || cmd == vcfp_pkg::CMD_LIGHT_ON) begin
      light_manual_now = 1'b1;
      lamp_on_now      = (cmd == vcfp_pkg::CMD_LIGHT_ON);
      light_acks++;
      queue_ack(frame_buf[2], cmd);
    end else begin
      frames_dropped++;
    end
  endtask

  task automatic check_ack_beat();
    ack_beat_t want;
    ack_beat_t got;
    got = '{tx_byte, last_byte, fan_level, fan_duty, fan_manual, lamp_on, light_manual};
    beats_checked++;
    if (ack_beats_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result tx_byte=%h last=%b", $realtime, tx_byte, last_byte);
      return;
    end
    want = ack_beats_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d differs", $realtime, beats_checked);
        $display("  expected tx=%h last=%b lvl=%0d duty=%0d fm=%b lon=%b lm=%b",
                 want.tx_byte, want.last_byte, want.fan_level, want.fan_duty,
                 want.fan_manual, want.lamp_on, want.light_manual);
        $display("  actual   tx=%h last=%b lvl=%0d duty=%0d fm=%b lon=%b lm=%b",
                 got.tx_byte, got.last_byte, got.fan_level, got.fan_duty,
                 got.fan_manual, got.lamp_on, got.light_manual);
      end
    end
  endtask

  // predict on accepted bytes first, then check popped results
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) parse_rx_byte(rx_byte);
      if (pop && !empty) check_ack_beat();
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] h2, input logic [7:0] frame_type,
                            input logic [7:0] cmd, input logic [7:0] ft);
    send_byte(vcfp_pkg::HDR1);
    send_byte(h2);
    send_byte(frame_type);
    send_byte(cmd);
    send_byte(ft);
  endtask

  task automatic wait_drained();
    while (ack_beats_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_fan_commands();
    send_frame(vcfp_pkg::HDR2, 8'h00, vcfp_pkg::CMD_FAN_FIRST, vcfp_pkg::FOOTER);
    send_frame(vcfp_pkg::HDR2, 8'hFF, vcfp_pkg::CMD_FAN_LAST, vcfp_pkg::FOOTER);
  endtask

  task automatic test_light_commands();
    // header byte in the type slot is just data
    send_frame(vcfp_pkg::HDR2, vcfp_pkg::HDR1, vcfp_pkg::CMD_LIGHT_ON, vcfp_pkg::FOOTER);
    send_frame(vcfp_pkg::HDR2, 8'h5A, vcfp_pkg::CMD_LIGHT_OFF, vcfp_pkg::FOOTER);
  endtask

  task automatic test_bad_frames();
    // second header byte replaced by a new start byte: no resync
    send_frame(vcfp_pkg::HDR1, vcfp_pkg::HDR2, vcfp_pkg::CMD_FAN_FIRST, vcfp_pkg::FOOTER);
    send_frame(vcfp_pkg::HDR2, 8'h01, vcfp_pkg::CMD_FAN_LAST, 8'hFA);
    send_frame(vcfp_pkg::HDR2, 8'h02, 8'h0C, vcfp_pkg::FOOTER);
    @(negedge clk);
    push <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  cmd;
    idle_pct  = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        case ($urandom_range(6))
          5:       cmd = vcfp_pkg::CMD_LIGHT_OFF;
          6:       cmd = vcfp_pkg::CMD_LIGHT_ON;
          default: cmd = vcfp_pkg::CMD_FAN_FIRST + 8'($urandom_range(4));
        endcase
        send_frame(vcfp_pkg::HDR2, 8'($urandom), cmd, vcfp_pkg::FOOTER);
        sent += 5;
      end else if (pick < 80) begin
        send_frame(vcfp_pkg::HDR2, 8'($urandom), 8'($urandom), vcfp_pkg::FOOTER);
        sent += 5;
      end else if (pick < 90) begin
        if ($urandom_range(1))
          send_frame(8'($urandom), 8'($urandom), vcfp_pkg::CMD_FAN_FIRST, vcfp_pkg::FOOTER);
        else
          send_frame(vcfp_pkg::HDR2, 8'($urandom), vcfp_pkg::CMD_LIGHT_ON, 8'($urandom));
        sent += 5;
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
    @(negedge clk);
    push <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_noise();
    test_fan_commands();
    test_light_commands();
    test_bad_frames();
    test_random_traffic(0, 0, 110);
    test_random_traffic(82, 0, 110);
    test_random_traffic(0, 82, 110);
    test_random_traffic(38, 38, 120);

    repeat (20) @(posedge clk);
    if (ack_beats_due.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", ack_beats_due.size());
    end
    $display("sent %0d bytes: %0d fan and %0d light acks, %0d frames dropped",
             bytes_sent, fan_acks, light_acks, frames_dropped);
    $display("checked %0d result bytes, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("voice_command_frame_parser: match");
    end else begin
      $display("voice_command_frame_parser: mismatch");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timed out with %0d results outstanding", ack_beats_due.size());
    $display("voice_command_frame_parser: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/vcfp_pkg.sv
sv/vcfp_front.sv
sv/vcfp_queue.sv
sv/vcfp_back.sv
sv/voice_command_frame_parser.sv
dv/voice_command_frame_parser_tb.sv
